/* rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// Text console character writer package
// Shared geometry, beat formats and command encodings for the console blocks.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry.
  localparam int COLS   = 80;
  localparam int ROWS   = 25;
  localparam int CELLS  = COLS * ROWS;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CELL_W = 16;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes on the input beat.
  localparam logic [1:0] OP_PUT        = 2'd0;
  localparam logic [1:0] OP_SET_CURSOR = 2'd1;
  localparam logic [1:0] OP_READ       = 2'd2;

  localparam logic [7:0] NEWLINE_CODE     = 8'h0a;
  localparam logic [7:0] DEFAULT_ATTR_RST = 8'h0f;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       char_code;
    logic [7:0]       attr;
    logic             use_position;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } in_beat_t;

  typedef struct packed {
    logic [COL_W-1:0] cursor_col_out;
    logic [ROW_W-1:0] cursor_row_out;
    logic             scrolled;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
  } out_beat_t;

  // Classified command as it sits in the queue.
  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_NEWLINE,
    CMD_SET_CURSOR,
    CMD_READ,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic             use_position;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [7:0]       char_code;
    logic [7:0]       attr;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_CLEAR
  } back_state_t;

  // Linear cell address of a row/column pair.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(r) * ADDR_W'(COLS);
    return base + ADDR_W'(c);
  endfunction

endpackage

/* rtl/tcw_front.sv */
// ----------------------------------------------------------------------------
// Text console front end
// Holds the default attribute register, accepts input beats and classifies
// them into queue commands with saturated positions and resolved attributes.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  tcw_pkg::in_beat_t cmd_data,
  input  logic              hold,
  input  logic              q_full,
  output logic              push,
  output tcw_pkg::cmd_t     push_cmd
);
  import tcw_pkg::*;

  logic [7:0] default_attr;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= DEFAULT_ATTR_RST;
    end else if (cfg_we) begin
      default_attr <= cfg_data;
    end
  end

  assign cmd_stall = q_full | hold;
  assign push      = cmd_valid & ~cmd_stall;

  always_comb begin
    push_cmd              = '0;
    push_cmd.use_position = cmd_data.use_position;
    push_cmd.char_code    = cmd_data.char_code;
    // Positions beyond the screen clamp to the last column or row.
    push_cmd.col  = (cmd_data.col > COL_W'(COLS - 1)) ? COL_W'(COLS - 1) : cmd_data.col;
    push_cmd.row  = (cmd_data.row > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : cmd_data.row;
    push_cmd.attr = (cmd_data.attr == 8'd0) ? default_attr : cmd_data.attr;
    case (cmd_data.op)
      OP_PUT: begin
        push_cmd.kind = (cmd_data.char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_PUT;
      end
      OP_SET_CURSOR: push_cmd.kind = CMD_SET_CURSOR;
      OP_READ:       push_cmd.kind = CMD_READ;
      default:       push_cmd.kind = CMD_NOP;
    endcase
  end

endmodule

/* rtl/tcw_queue.sv */
// ----------------------------------------------------------------------------
// Text console command queue
// Short first-in first-out buffer that decouples the front end from the
// back end.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  tcw_pkg::cmd_t          push_cmd,
  input  logic                   pop,
  output tcw_pkg::cmd_t          head,
  output tcw_pkg::queue_status_t status
);
  import tcw_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (!do_push && do_pop) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

/* rtl/tcw_back.sv */
// ----------------------------------------------------------------------------
// Text console back end
// Owns the screen memory and cursor, carries out queued commands, runs the
// reset clearing pass and the scroll pass, and holds the result register.
// ----------------------------------------------------------------------------
module tcw_back (
  input  logic                   clk,
  input  logic                   rst,
  input  tcw_pkg::cmd_t          head,
  input  tcw_pkg::queue_status_t q_status,
  output logic                   pop,
  output logic                   init_busy,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output tcw_pkg::out_beat_t     rsp_data
);
  import tcw_pkg::*;

  localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW_A  = ADDR_W'(CELLS - COLS);
  localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata;

  back_state_t       state, state_next;
  logic [ADDR_W-1:0] ptr, ptr_next;
  logic              scroll_flag, scroll_flag_next;
  logic              mv_valid, mv_valid_next;
  logic [ADDR_W-1:0] mv_addr, mv_addr_next;
  logic [COL_W-1:0]  cursor_col, cursor_col_next;
  logic [ROW_W-1:0]  cursor_row, cursor_row_next;
  logic              rsp_valid_next;
  out_beat_t         rsp_data_next;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  logic              res_free;
  logic [COL_W-1:0]  tgt_col;
  logic [ROW_W-1:0]  tgt_row;
  logic [COL_W-1:0]  put_col;
  logic [ROW_W-1:0]  put_row;
  logic              put_wrap;
  logic              row_end;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  // Where a put lands and where the cursor goes afterward.
  always_comb begin
    tgt_col = head.use_position ? head.col : cursor_col;
    tgt_row = head.use_position ? head.row : cursor_row;
    row_end = (head.kind == CMD_NEWLINE) || (tgt_col == LAST_COL);
    put_wrap = row_end && (tgt_row == LAST_ROW);
    if (row_end) begin
      put_col = '0;
      put_row = put_wrap ? tgt_row : tgt_row + ROW_W'(1);
    end else begin
      put_col = tgt_col + COL_W'(1);
      put_row = tgt_row;
    end
  end

  assign res_free  = ~rsp_valid | ~rsp_stall;
  assign init_busy = (state == ST_CLEAR) && !scroll_flag;

  always_comb begin
    state_next       = state;
    ptr_next         = ptr;
    scroll_flag_next = scroll_flag;
    mv_valid_next    = 1'b0;
    mv_addr_next     = mv_addr;
    cursor_col_next  = cursor_col;
    cursor_row_next  = cursor_row;
    rsp_valid_next   = rsp_valid & rsp_stall;
    rsp_data_next    = rsp_data;
    mem_we           = 1'b0;
    mem_waddr        = ptr;
    mem_wdata        = '0;
    mem_raddr        = ptr;
    pop              = 1'b0;

    case (state)
      ST_IDLE: begin
        if (!q_status.empty && res_free) begin
          pop = 1'b1;
          rsp_data_next = '0;
          case (head.kind)
            CMD_PUT, CMD_NEWLINE: begin
              if (head.kind == CMD_PUT) begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(tgt_row, tgt_col);
                mem_wdata = {head.attr, head.char_code};
              end
              cursor_col_next = put_col;
              cursor_row_next = put_row;
              if (put_wrap) begin
                state_next       = ST_SCROLL;
                ptr_next         = COLS_A;
                scroll_flag_next = 1'b1;
              end else begin
                rsp_valid_next = 1'b1;
                rsp_data_next.cursor_col_out = put_col;
                rsp_data_next.cursor_row_out = put_row;
              end
            end
            CMD_SET_CURSOR: begin
              cursor_col_next = head.col;
              cursor_row_next = head.row;
              rsp_valid_next  = 1'b1;
              rsp_data_next.cursor_col_out = head.col;
              rsp_data_next.cursor_row_out = head.row;
            end
            CMD_READ: begin
              mem_raddr  = cell_addr(head.row, head.col);
              state_next = ST_READ;
            end
            default: begin
              rsp_valid_next = 1'b1;
              rsp_data_next.cursor_col_out = cursor_col;
              rsp_data_next.cursor_row_out = cursor_row;
            end
          endcase
        end
      end

      ST_READ: begin
        state_next     = ST_IDLE;
        rsp_valid_next = 1'b1;
        rsp_data_next  = '0;
        rsp_data_next.cursor_col_out = cursor_col;
        rsp_data_next.cursor_row_out = cursor_row;
        rsp_data_next.cell_char      = rdata[7:0];
        rsp_data_next.cell_attr      = rdata[15:8];
      end

      ST_SCROLL: begin
        // Read one row down, write the word read last cycle one row up.
        mem_raddr     = ptr;
        mv_valid_next = 1'b1;
        mv_addr_next  = ptr - COLS_A;
        if (mv_valid) begin
          mem_we    = 1'b1;
          mem_waddr = mv_addr;
          mem_wdata = rdata;
        end
        if (ptr == LAST_ADDR) begin
          state_next = ST_CLEAR;
          ptr_next   = LAST_ROW_A;
        end else begin
          ptr_next = ptr + ADDR_W'(1);
        end
      end

      ST_CLEAR: begin
        mem_we = 1'b1;
        if (mv_valid) begin
          mem_waddr = mv_addr;
          mem_wdata = rdata;
        end else begin
          mem_waddr = ptr;
          mem_wdata = '0;
          if (ptr == LAST_ADDR) begin
            state_next       = ST_IDLE;
            scroll_flag_next = 1'b0;
            if (scroll_flag) begin
              rsp_valid_next = 1'b1;
              rsp_data_next  = '0;
              rsp_data_next.cursor_col_out = cursor_col;
              rsp_data_next.cursor_row_out = cursor_row;
              rsp_data_next.scrolled       = 1'b1;
            end
          end else begin
            ptr_next = ptr + ADDR_W'(1);
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      ptr         <= '0;
      scroll_flag <= 1'b0;
      mv_valid    <= 1'b0;
      cursor_col  <= '0;
      cursor_row  <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      ptr         <= ptr_next;
      scroll_flag <= scroll_flag_next;
      mv_valid    <= mv_valid_next;
      cursor_col  <= cursor_col_next;
      cursor_row  <= cursor_row_next;
      rsp_valid   <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mv_addr  <= mv_addr_next;
    rsp_data <= rsp_data_next;
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (cursor_col <= LAST_COL) && (cursor_row <= LAST_ROW))
    else $error("cursor left the screen");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !pop)
    else $error("command taken while a multi-cycle operation runs");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.scrolled) |->
      (rsp_data.cursor_col_out == '0) && (rsp_data.cursor_row_out == LAST_ROW))
    else $error("scroll result with cursor off the start of the last row");

  a_scroll_flagged: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCROLL) |-> scroll_flag)
    else $error("scroll pass without scroll flag");

endmodule

/* rtl/text_console_char_writer.sv */
// ----------------------------------------------------------------------------
// Text console character writer
// Character cell screen store with cursor, put, set-cursor and read commands.
// ----------------------------------------------------------------------------
// The console keeps an 80 x 25 screen of 16-bit cells (character in the low
// byte, attribute in the high byte) in a single memory, plus a cursor. Each
// accepted input beat produces exactly one output beat that reports the cursor
// after the command, whether the screen scrolled, and for a read the cell
// contents. A front end classifies beats into a two-entry command queue; the
// back end works them off. A set-cursor, an unknown op, or a put that does not
// leave the screen is done in the idle state alone; a read also passes through
// a read state because the memory read port is registered. A put or newline
// that runs past the last cell triggers a scroll: the back end walks the
// memory with its one read and one write port, moving each cell up a row and
// then zeroing the last row, before the result beat is produced. After reset
// the back end clears the whole memory, one cell a cycle, and holds cmd_stall
// high for that time; default_attr writes are taken during the pass. Result
// beats wait in an output register; the back end takes a new command only
// while that register is empty or is emptied in the same cycle.
// ----------------------------------------------------------------------------
module text_console_char_writer (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  tcw_pkg::in_beat_t  cmd_data,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output tcw_pkg::out_beat_t rsp_data
);
  import tcw_pkg::*;

  logic          push;
  cmd_t          push_cmd;
  logic          pop;
  cmd_t          head;
  queue_status_t q_status;
  logic          init_busy;

  // Classify incoming beats; hold off while the reset clearing pass runs.
  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .hold      (init_busy),
    .q_full    (q_status.full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // The queue lets the front keep accepting while a read or scroll runs.
  tcw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // The back end owns the screen memory, the cursor and the result register.
  tcw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .init_busy (init_busy),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Text console character writer testbench
// Checks the console against a cycle-free model of its screen store and cursor.
// ----------------------------------------------------------------------------
// The bench keeps a copy of the screen cells, the cursor and the default
// attribute. Every command beat that the block accepts is applied to that copy
// right away. The bench then queues the result beat it expects. A separate
// process takes each result beat as it leaves the block and compares it, field
// by field, with the oldest expected beat.
//
// The tests run in turn: a short directed set of corner cases, a pass over the
// default attribute register, a back-pressure test, and four phases of random
// traffic with different idle and stall mixes. The random traffic mostly types
// text at the cursor, so that the screen fills and scrolls. The rest of the
// beats move the cursor, read cells back, put at explicit positions, or send
// noise and undefined opcodes.
// ----------------------------------------------------------------------------
module tb;
  import tcw_pkg::*;

  // The op field has one encoding that the package leaves unnamed.
  localparam logic [1:0] OP_UNDEFINED = 2'd3;

  // A scroll walks the whole store. The random traffic keeps the number of
  // scrolls at or below this cap to bound the run time.
  localparam int SCROLL_BUDGET = 120;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int REPORT_LIMIT  = 10;

  logic      clk;
  logic      rst       = 1'b1;
  logic      cfg_we    = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  in_beat_t  cmd_data  = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  out_beat_t rsp_data;

  // Copy of the block's state as it should be after every accepted beat.
  logic [15:0]      shadow_cells [CELLS] = '{default: '0};
  logic [COL_W-1:0] shadow_col          = '0;
  logic [ROW_W-1:0] shadow_row          = '0;
  logic [7:0]       shadow_default_attr = DEFAULT_ATTR_RST;

  out_beat_t   pending_views[$];
  out_beat_t   oldest_view;
  int unsigned mismatch_count = 0;
  int unsigned scroll_total   = 0;
  int unsigned cycle_count    = 0;

  // Traffic shaping knobs, set by the test tasks.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holdoff_left   = 0;
  bit          cmd_offered    = 1'b0;

  text_console_char_writer DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_data (cmd_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data (rsp_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run guard. A correct run stays well below the limit, even with every
  // scroll in the budget and the heaviest stall mix.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver side. A long hold-off, when one is requested, takes priority over
  // the random stall mix. Each edge makes exactly one assignment to rsp_stall.
  always @(posedge clk) begin
    if (holdoff_left > 0) begin
      rsp_stall <= 1'b1;
      holdoff_left--;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker. A beat leaves the block at an edge where rsp_valid is high
  // and rsp_stall is low. Both are sampled as they were just before the edge.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_views.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("result beat with nothing pending: col=%0d row=%0d scr=%0b ch=%h at=%h",
                   rsp_data.cursor_col_out, rsp_data.cursor_row_out,
                   rsp_data.scrolled, rsp_data.cell_char, rsp_data.cell_attr);
      end else begin
        oldest_view = pending_views.pop_front();
        if (rsp_data.cursor_col_out !== oldest_view.cursor_col_out ||
            rsp_data.cursor_row_out !== oldest_view.cursor_row_out ||
            rsp_data.scrolled !== oldest_view.scrolled ||
            rsp_data.cell_char !== oldest_view.cell_char ||
            rsp_data.cell_attr !== oldest_view.cell_attr) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("result mismatch: expected col=%0d row=%0d scr=%0b ch=%h at=%h",
                     oldest_view.cursor_col_out, oldest_view.cursor_row_out,
                     oldest_view.scrolled, oldest_view.cell_char,
                     oldest_view.cell_attr);
            $display("                 got      col=%0d row=%0d scr=%0b ch=%h at=%h",
                     rsp_data.cursor_col_out, rsp_data.cursor_row_out,
                     rsp_data.scrolled, rsp_data.cell_char, rsp_data.cell_attr);
          end
        end
      end
    end
  end

  // Positions above the screen edge clamp to the last column or row.
  function automatic int unsigned clamp_col(input logic [COL_W-1:0] c);
    return (int'(c) > COLS - 1) ? COLS - 1 : int'(c);
  endfunction

  function automatic int unsigned clamp_row(input logic [ROW_W-1:0] r);
    return (int'(r) > ROWS - 1) ? ROWS - 1 : int'(r);
  endfunction

  // Applies one command to the shadow screen and returns the result beat that
  // the block must produce for it.
  function automatic out_beat_t apply_console_cmd(input in_beat_t b);
    out_beat_t   view;
    int unsigned c;
    int unsigned r;
    int unsigned pos;
    logic [7:0]  cell_attr;
    view = '0;
    c = clamp_col(b.col);
    r = clamp_row(b.row);
    case (b.op)
      OP_PUT: begin
        if (!b.use_position) begin
          c = shadow_col;
          r = shadow_row;
        end
        // A newline writes nothing and lands on the last column of its row,
        // so the step below moves to the start of the next row.
        if (b.char_code == NEWLINE_CODE) begin
          pos = r * COLS + COLS - 1;
        end else begin
          pos = r * COLS + c;
          cell_attr = (b.attr == 8'h00) ? shadow_default_attr : b.attr;
          shadow_cells[pos] = {cell_attr, b.char_code};
        end
        pos++;
        // Running off the last cell moves every row up and blanks the last.
        if (pos >= CELLS) begin
          for (int i = 0; i < CELLS - COLS; i++)
            shadow_cells[i] = shadow_cells[i + COLS];
          for (int i = CELLS - COLS; i < CELLS; i++)
            shadow_cells[i] = '0;
          pos -= COLS;
          view.scrolled = 1'b1;
          scroll_total++;
        end
        shadow_col = COL_W'(pos % COLS);
        shadow_row = ROW_W'(pos / COLS);
      end
      OP_SET_CURSOR: begin
        shadow_col = COL_W'(c);
        shadow_row = ROW_W'(r);
      end
      OP_READ: begin
        view.cell_char = shadow_cells[r * COLS + c][7:0];
        view.cell_attr = shadow_cells[r * COLS + c][15:8];
      end
      default: begin
        // An undefined op leaves everything alone.
      end
    endcase
    view.cursor_col_out = shadow_col;
    view.cursor_row_out = shadow_row;
    return view;
  endfunction

  // True when a put would run past the last cell from the current state.
  function automatic bit scrolls_screen(input in_beat_t b);
    int unsigned c;
    int unsigned r;
    if (b.op != OP_PUT)
      return 1'b0;
    c = b.use_position ? clamp_col(b.col) : int'(shadow_col);
    r = b.use_position ? clamp_row(b.row) : int'(shadow_row);
    return (r == ROWS - 1) && (b.char_code == NEWLINE_CODE || c == COLS - 1);
  endfunction

  function automatic in_beat_t make_cmd(input logic [1:0] op, input logic [7:0] ch,
                                        input logic [7:0] at, input logic usep,
                                        input logic [COL_W-1:0] col,
                                        input logic [ROW_W-1:0] row);
    in_beat_t b;
    b.op           = op;
    b.char_code    = ch;
    b.attr         = at;
    b.use_position = usep;
    b.col          = col;
    b.row          = row;
    return b;
  endfunction

  // Random command, weighted toward typing at the cursor so that the screen
  // fills up and scrolls. Col and row start out as random bits, even where
  // the op ignores them.
  function automatic in_beat_t random_console_cmd();
    in_beat_t    b;
    int unsigned pick;
    logic [7:0]  ch;
    logic [7:0]  at;
    logic [31:0] noise;
    pick = $urandom_range(99);
    ch = ($urandom_range(99) < 85) ? 8'($urandom_range(126, 32)) : 8'($urandom_range(255));
    at = ($urandom_range(99) < 25) ? 8'h00 : 8'($urandom_range(255));
    b = make_cmd(OP_PUT, ch, at, 1'b0, COL_W'($urandom_range(127)),
                 ROW_W'($urandom_range(31)));
    if (pick < 8) begin
      b.char_code = NEWLINE_CODE;
    end else if (pick < 68) begin
      // Plain typing at the cursor.
    end else if (pick < 76) begin
      b.use_position = 1'b1;
    end else if (pick < 86) begin
      b.op = OP_SET_CURSOR;
      if ($urandom_range(99) < 60) begin
        b.col = COL_W'($urandom_range(COLS - 1));
        b.row = ROW_W'($urandom_range(ROWS - 1));
      end
    end else if (pick < 97) begin
      b.op = OP_READ;
      // Half of the reads look at the cell just typed.
      if ($urandom_range(1) == 0) begin
        b.col = (shadow_col == 0) ? '0 : shadow_col - 1'b1;
        b.row = shadow_row;
      end
    end else begin
      noise = $urandom();
      b = noise[$bits(in_beat_t)-1:0];
      if ($urandom_range(1) == 0)
        b.op = OP_UNDEFINED;
    end
    if (scroll_total >= SCROLL_BUDGET && scrolls_screen(b))
      b = make_cmd(OP_SET_CURSOR, ch, at, 1'b0, COL_W'($urandom_range(COLS - 1)),
                   ROW_W'($urandom_range(ROWS - 2)));
    return b;
  endfunction

  task automatic drop_cmd_valid();
    if (cmd_offered) begin
      cmd_valid   <= 1'b0;
      cmd_offered  = 1'b0;
    end
  endtask

  // Offers one command beat and returns in the time step of the edge that took
  // it. Valid is left high so that a following beat can go out back to back.
  task automatic send_cmd(input in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      drop_cmd_valid();
      @(posedge clk);
    end
    cmd_valid   <= 1'b1;
    cmd_data    <= b;
    cmd_offered  = 1'b1;
    @(posedge clk);
    while (cmd_stall)
      @(posedge clk);
    pending_views.push_back(apply_console_cmd(b));
  endtask

  // Stops offering commands and waits for every pending result.
  task automatic wait_drain();
    drop_cmd_valid();
    while (pending_views.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_default_attr(input logic [7:0] value);
    wait_drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_default_attr = value;
  endtask

  // Corner cases: reset contents, default attribute, clamping of positions,
  // newlines in the middle and on the last row, scrolling from a put on the
  // last cell, and the undefined op.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0));
    send_cmd(make_cmd(OP_PUT, 8'h41, 8'h00, 1'b0, 7'd127, 5'd31));
    send_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0));
    send_cmd(make_cmd(OP_PUT, 8'hff, 8'hff, 1'b1, 7'd79, 5'd0));
    send_cmd(make_cmd(OP_READ, 8'hff, 8'hff, 1'b1, 7'd79, 5'd0));
    // A put far outside the screen clamps to the last cell and scrolls.
    send_cmd(make_cmd(OP_PUT, 8'h00, 8'h01, 1'b1, 7'd127, 5'd31));
    send_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 7'd127, 5'd31));
    send_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 7'd79, 5'd23));
    send_cmd(make_cmd(OP_SET_CURSOR, 8'h00, 8'h00, 1'b0, 7'd127, 5'd31));
    send_cmd(make_cmd(OP_SET_CURSOR, 8'hff, 8'hff, 1'b1, 7'd0, 5'd0));
    send_cmd(make_cmd(OP_PUT, NEWLINE_CODE, 8'h00, 1'b0, 7'd0, 5'd0));
    send_cmd(make_cmd(OP_PUT, NEWLINE_CODE, 8'h22, 1'b1, 7'd5, 5'd24));
    send_cmd(make_cmd(OP_PUT, NEWLINE_CODE, 8'hff, 1'b1, 7'd127, 5'd31));
    send_cmd(make_cmd(OP_PUT, NEWLINE_CODE, 8'h00, 1'b1, 7'd0, 5'd12));
    send_cmd(make_cmd(OP_UNDEFINED, 8'hff, 8'hff, 1'b1, 7'd127, 5'd31));
    send_cmd(make_cmd(OP_UNDEFINED, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0));
    // Typing on the very last cell scrolls through the cursor path too.
    send_cmd(make_cmd(OP_SET_CURSOR, 8'h00, 8'h00, 1'b0, 7'd79, 5'd24));
    send_cmd(make_cmd(OP_PUT, 8'h7e, 8'h80, 1'b0, 7'd0, 5'd0));
    send_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 1'b0, 7'd79, 5'd23));
    send_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 1'b1, 7'd0, 5'd0));
  endtask

  // Walks the default attribute through both extremes, a random value and
  // back to its reset value, reading back a cell written under each.
  task automatic test_default_attr();
    logic [7:0] settings [4];
    settings = '{8'h00, 8'hff, 8'($urandom_range(254, 1)), DEFAULT_ATTR_RST};
    for (int k = 0; k < 4; k++) begin
      write_default_attr(settings[k]);
      send_cmd(make_cmd(OP_PUT, 8'h30 + 8'(k), 8'h00, 1'b1, COL_W'(k), 5'd2));
      send_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 1'b0, COL_W'(k), 5'd2));
      send_cmd(make_cmd(OP_PUT, 8'h61, 8'h80, 1'b1, COL_W'(k + 10), 5'd3));
      send_cmd(make_cmd(OP_READ, 8'h00, 8'h00, 1'b0, COL_W'(k + 10), 5'd3));
    end
  endtask

  // The receiver holds off for a long stretch while commands keep coming, so
  // the queue and the output register fill and the block stalls its input.
  // Then the sender pauses until everything is back before going on.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_left   = 400;
    repeat (24)
      send_cmd(random_console_cmd());
    wait_drain();
    repeat (16)
      send_cmd(random_console_cmd());
  endtask

  task automatic test_random_traffic(input int unsigned beats,
                                     input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (beats)
      send_cmd(random_console_cmd());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // The block clears its store after reset and holds cmd_stall meanwhile;
    // the first send simply waits for that.
    test_directed();
    test_default_attr();
    test_backpressure();
    test_random_traffic(370, 0, 0);
    test_random_traffic(370, 60, 0);
    test_random_traffic(370, 0, 60);
    test_random_traffic(370, 26, 26);
    wait_drain();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Watch a little longer for stray result beats.
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_views.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
